>>> hw/rtl/vrbp_pkg.sv
// Shared types, constants and codes of the vertical recursive bilateral pass.
package vrbp_pkg;

   // Default geometry and fixed-point format.
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_FRAC_BITS = 16;

   // Field widths of the stream items.
   localparam int COLUMN_W = 10;
   localparam int PIXEL_W  = 8;
   localparam int TIDX_W   = 8;
   localparam int TVAL_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // Request queue between the front and the back.
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;

   // Action codes carried in tuser.
   localparam logic ACT_FILTER = 1'b0;
   localparam logic ACT_LOAD   = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKWARD = 2'd1;

   // One classified request as it travels through the queue and the pipeline.
   typedef struct packed {
      logic                load;
      logic                first;
      logic [COLUMN_W-1:0] column;
      logic [PIXEL_W-1:0]  pixel;
      logic [PIXEL_W-1:0]  prior;
      logic [TIDX_W-1:0]   tidx;
      logic [TVAL_W-1:0]   tval;
   } item_type;

   // Queue status reported by the front.
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [QCNT_W-1:0] count;
   } front_status_type;

   // Issue status reported by the back.
   typedef struct packed {
      logic issue;
      logic hazard;
   } back_status_type;

endpackage

>>> hw/rtl/vrbp_front.sv
// Front end: queues requests but drops out-of-range filter requests.
module vrbp_front
   import vrbp_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  item_type         in_item,
   output logic             head_valid,
   output item_type         head_item,
   input  logic             head_pop,
   output front_status_type status
);

   item_type          queue_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              accept;
   logic              in_range;
   logic              push;

   // A load always goes in; a filter request only when its column exists.
   assign in_range = (32'(in_item.column) < 32'(MAX_WIDTH));
   assign in_ready = (count_ff != QCNT_W'(QDEPTH));
   assign accept   = in_valid && in_ready;
   assign push     = accept && (in_item.load || in_range);

   assign head_valid = (count_ff != '0);
   assign head_item  = queue_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= in_item;
      end
   end

   assign status.push  = push;
   assign status.pop   = head_pop;
   assign status.count = count_ff;

endmodule

>>> hw/rtl/vrbp_back.sv
// Back end: column state memories, recursive update, divider and output register.
module vrbp_back
   import vrbp_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  item_type              head_item,
   output logic                  head_pop,
   input  logic [FRAC_BITS:0]    alpha,
   input  logic                  backward,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIXEL_W-1:0]    rsp_pixel,
   output logic [COLUMN_W-1:0]   rsp_column,
   output back_status_type       status
);

   localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int QW   = FRAC_BITS + 1;
   localparam int WW   = FRAC_BITS + 2;
   localparam int CLW  = FRAC_BITS + 10;
   localparam int PWW  = QW + WW;
   localparam int PCW  = QW + CLW;
   localparam int APW  = QW + PIXEL_W;
   localparam int SUMW = PCW + 1;
   localparam int ONE  = 1 << FRAC_BITS;
   localparam int NDIV = 9;

   // Memories.
   logic [TVAL_W-1:0]  range_table [256];
   logic [WW-1:0]      column_weight [MAX_WIDTH];
   logic [CLW-1:0]     column_color [MAX_WIDTH];
   logic [PIXEL_W-1:0] previous_row [MAX_WIDTH];

   // Pipeline registers.
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   item_type           s1_ff, s2_ff, s3_ff, s4_ff;
   logic [WW-1:0]      rd_w_ff, w2_ff, w4_ff;
   logic [CLW-1:0]     rd_c_ff, c2_ff, c4_ff;
   logic [PIXEL_W-1:0] rd_p_ff;
   logic [TVAL_W-1:0]  t_rd_ff;
   logic [PWW-1:0]     pw_ff;
   logic [PCW-1:0]     pc_ff;
   logic [APW-1:0]     ap_ff;

   // Divider stages.
   logic               dv_ff   [NDIV];
   item_type           ds_ff   [NDIV];
   logic [WW-1:0]      dw_ff   [NDIV];
   logic [CLW-1:0]     drem_ff [NDIV];
   logic [PIXEL_W-1:0] dq_ff   [NDIV];
   logic               dovf_ff [NDIV];

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  rsp_pixel_ff;
   logic [COLUMN_W-1:0] rsp_column_ff;

   logic               en;
   logic               hazard;
   logic [AW-1:0]      head_addr, s3_addr;
   logic [31:0]        head_col32, s3_col32;
   logic [PIXEL_W-1:0] diff;
   logic [QW-1:0]      r_clamped;
   logic [SUMW-1:0]    w_sum, c_sum;
   logic [WW-1:0]      w_new;
   logic [CLW-1:0]     c_new;
   logic [PIXEL_W-1:0] res_pre;
   logic [PIXEL_W:0]   res_avg;

   // The whole back end advances whenever the output register can move.
   assign en = !rsp_valid_ff || rsp_ready;

   // A filter request waits while an earlier request to its column has not written back.
   always_comb begin
      hazard = !head_item.load &&
               ((v1_ff && !s1_ff.load && s1_ff.column == head_item.column) ||
                (v2_ff && !s2_ff.load && s2_ff.column == head_item.column) ||
                (v3_ff && !s3_ff.load && s3_ff.column == head_item.column));
   end
   assign head_pop = en && head_valid && !hazard;

   assign head_col32 = 32'(head_item.column);
   assign s3_col32   = 32'(s3_ff.column);
   assign head_addr  = head_col32[AW-1:0];
   assign s3_addr    = s3_col32[AW-1:0];

   // Valid bits of the main stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= head_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Issue: read the column state and take table loads.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= head_item;
         rd_w_ff <= column_weight[head_addr];
         rd_c_ff <= column_color[head_addr];
         rd_p_ff <= previous_row[head_addr];
         if (head_pop && head_item.load) begin
            range_table[head_item.tidx] <= head_item.tval;
         end
      end
   end

   // Range table lookup by the difference from the row above.
   assign diff = (s1_ff.pixel > rd_p_ff) ? s1_ff.pixel - rd_p_ff : rd_p_ff - s1_ff.pixel;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff   <= s1_ff;
         w2_ff   <= rd_w_ff;
         c2_ff   <= rd_c_ff;
         t_rd_ff <= range_table[diff];
      end
   end

   // Products of the recursion.
   assign r_clamped = (32'(t_rd_ff) > 32'(ONE)) ? QW'(ONE) : QW'(t_rd_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= s2_ff;
         pw_ff <= PWW'(r_clamped) * PWW'(w2_ff);
         pc_ff <= PCW'(r_clamped) * PCW'(c2_ff);
         ap_ff <= APW'(alpha) * APW'(s2_ff.pixel);
      end
   end

   // Sums with saturation; the first row restarts the column.
   always_comb begin
      w_sum = SUMW'(alpha) + SUMW'(pw_ff >> FRAC_BITS);
      c_sum = SUMW'(ap_ff) + SUMW'(pc_ff >> FRAC_BITS);
      if (s3_ff.first) begin
         w_new = WW'(ONE);
         c_new = CLW'(s3_ff.pixel) << FRAC_BITS;
      end else begin
         w_new = (w_sum > SUMW'({WW{1'b1}})) ? {WW{1'b1}} : w_sum[WW-1:0];
         c_new = (c_sum > SUMW'({CLW{1'b1}})) ? {CLW{1'b1}} : c_sum[CLW-1:0];
      end
   end

   // Write back the column state.
   always_ff @(posedge clock) begin
      if (en && v3_ff && !s3_ff.load) begin
         column_weight[s3_addr] <= w_new;
         column_color[s3_addr]  <= c_new;
         previous_row[s3_addr]  <= s3_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff <= s3_ff;
         w4_ff <= w_new;
         c4_ff <= c_new;
      end
   end

   // Divider, first stage: a quotient of 256 or more (or a zero weight) saturates.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ds_ff[0]   <= s4_ff;
         dw_ff[0]   <= w4_ff;
         drem_ff[0] <= c4_ff;
         dq_ff[0]   <= '0;
         dovf_ff[0] <= (c4_ff >= (CLW'(w4_ff) << PIXEL_W));
      end
   end

   // Divider, one quotient bit per stage from the top.
   for (genvar s = 1; s < NDIV; s++) begin : g_div
      localparam int K = NDIV - 1 - s;
      logic [CLW-1:0] shifted;
      logic           take;

      assign shifted = CLW'(dw_ff[s-1]) << K;
      assign take    = !dovf_ff[s-1] && (drem_ff[s-1] >= shifted);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (en) begin
            dv_ff[s] <= dv_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ds_ff[s]   <= ds_ff[s-1];
            dw_ff[s]   <= dw_ff[s-1];
            dovf_ff[s] <= dovf_ff[s-1];
            drem_ff[s] <= take ? drem_ff[s-1] - shifted : drem_ff[s-1];
            dq_ff[s]   <= dq_ff[s-1] | (take ? PIXEL_W'(1) << K : '0);
         end
      end
   end

   // Final value and the backward average.
   always_comb begin
      if (ds_ff[NDIV-1].first) begin
         res_pre = ds_ff[NDIV-1].pixel;
      end else if (dovf_ff[NDIV-1]) begin
         res_pre = '1;
      end else begin
         res_pre = dq_ff[NDIV-1];
      end
      res_avg = ((PIXEL_W+1)'(res_pre) + (PIXEL_W+1)'(ds_ff[NDIV-1].prior) + 1'b1) >> 1;
   end

   assign rsp_valid_in = en ? (dv_ff[NDIV-1] && !ds_ff[NDIV-1].load) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_pixel_ff  <= backward ? res_avg[PIXEL_W-1:0] : res_pre;
         rsp_column_ff <= ds_ff[NDIV-1].column;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_column    = rsp_column_ff;
   assign status.issue  = head_pop;
   assign status.hazard = head_valid && hazard;

endmodule

>>> hw/rtl/vertical_recursive_bilateral_pass.sv
// Top level of the vertical recursive bilateral pass: ports, registers, assertions.
//
// Requests enter on the req_ stream, one per cycle while ready. tuser carries the
// action (filter a pixel or load a range table entry) and the first-row flag;
// tdata carries column, pixel, prior value, table index and table value. A filter
// request gives one response on the rsp_ stream with the filtered pixel and its
// column; a table load and a column at or beyond MAX_WIDTH give none.
// The csr_ channel writes alpha (index 0) and the backward flag (index 1); it
// is always ready; it is to be written only while the block is idle, which the
// block itself does not enforce. Throughput is one request per cycle when no
// column hazard or back-pressure holds the pipe. A filter request is held back
// while a filter request in the read, lookup or multiply stage has the same
// column, since column state is written back only in the add step after the
// multiply. From acceptance to a valid response a request passes the memory
// read, table lookup, multiply, add, the nine divider stages and the output
// register. When a response waits and rsp_tready is low the back end holds
// while the request queue of four entries keeps taking requests until it fills.
// Reset clears all valid bits and the queue and restores alpha and the
// backward flag; the memories hold no defined value until written.
module vertical_recursive_bilateral_pass
   import vrbp_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: column[9:0], pixel[17:10], prior_value[25:18], table_index[33:26],
   //        table_value[50:34], zero pad [55:51]
   input  logic [55:0]           req_tdata,
   // tuser: action[0], first_row[1]
   input  logic [1:0]            req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: out_pixel[7:0], out_column[17:8], zero pad [23:18]
   output logic [23:0]           rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QW      = FRAC_BITS + 1;
   localparam int ALPHA_W = (QW > CSR_DATA_W) ? QW : CSR_DATA_W;
   localparam int ONE     = 1 << FRAC_BITS;

   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic                backward_ff, backward_in;
   logic [QW-1:0]       alpha_clamped;
   item_type            in_item;
   logic                head_valid;
   item_type            head_item;
   logic                head_pop;
   front_status_type    front_status;
   back_status_type     back_status;
   logic [PIXEL_W-1:0]  rsp_pixel;
   logic [COLUMN_W-1:0] rsp_column;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      alpha_in    = alpha_ff;
      backward_in = backward_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA:    alpha_in    = ALPHA_W'(csr_wdata);
            CSR_BACKWARD: backward_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= ALPHA_W'(ONE / 2);
         backward_ff <= 1'b0;
      end else begin
         alpha_ff    <= alpha_in;
         backward_ff <= backward_in;
      end
   end

   // Weights above one act as one.
   assign alpha_clamped = (32'(alpha_ff) > 32'(ONE)) ? QW'(ONE) : QW'(alpha_ff);

   // Unpack the request.
   assign in_item.load   = (req_tuser[0] == ACT_LOAD);
   assign in_item.first  = req_tuser[1];
   assign in_item.column = req_tdata[9:0];
   assign in_item.pixel  = req_tdata[17:10];
   assign in_item.prior  = req_tdata[25:18];
   assign in_item.tidx   = req_tdata[33:26];
   assign in_item.tval   = req_tdata[50:34];

   vrbp_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (in_item),
      .head_valid(head_valid),
      .head_item (head_item),
      .head_pop  (head_pop),
      .status    (front_status)
   );

   vrbp_back #(
      .MAX_WIDTH(MAX_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_item (head_item),
      .head_pop  (head_pop),
      .alpha     (alpha_clamped),
      .backward  (backward_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_pixel (rsp_pixel),
      .rsp_column(rsp_column),
      .status    (back_status)
   );

   assign rsp_tdata = {6'd0, rsp_column, rsp_pixel};

   // The queue never takes a request from an empty slot.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      front_status.pop |-> (front_status.count != '0))
      else $error("request queue popped while empty");

   // The fill count follows the pushes and pops of the previous cycle.
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> front_status.count == $past(front_status.count)
         + QCNT_W'($past(front_status.push)) - QCNT_W'($past(front_status.pop)))
      else $error("request queue count out of step");

   // A request whose column is still being written back is never issued.
   a_no_issue_hazard: assert property (@(posedge clock) disable iff (reset)
      back_status.hazard |-> !back_status.issue)
      else $error("request issued over a column hazard");

endmodule
